// ===== sv/tsrr_pkg.sv =====
// Package for the timestamped sample ring: shared constants, codes and the cell control struct.
// Used by every module of the block; depends on nothing else.
package tsrr_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int TIME_W       = 64;
  localparam int BITS_W       = 64;
  localparam int HELD_W       = 7;
  localparam int SPAN_W       = 32;

  localparam logic [SPAN_W-1:0] RETENTION_RESET = 32'd3600000;
  localparam logic [TIME_W-1:0] TIME_MIN        = {1'b1, {(TIME_W-1){1'b0}}};

  // Operation codes on the op input.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result kinds.
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register byte address of retention_span.
  localparam logic [1:0] REG_RETENTION = 2'd0;

  // Control handed to every cell of the row.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== sv/tsrr_cell.sv =====
// One storage cell of the sample row: holds a timestamp and a raw value.
// Depends on tsrr_pkg for the control struct and the field widths.
module tsrr_cell (
  input  logic                          clk,
  input  tsrr_pkg::cell_ctrl_t          ctrl,
  input  logic [tsrr_pkg::TIME_W-1:0]   near_stamp,
  input  logic [tsrr_pkg::BITS_W-1:0]   near_value,
  input  logic [tsrr_pkg::TIME_W-1:0]   new_stamp,
  input  logic [tsrr_pkg::BITS_W-1:0]   new_value,
  output logic [tsrr_pkg::TIME_W-1:0]   stamp,
  output logic [tsrr_pkg::BITS_W-1:0]   value
);
  import tsrr_pkg::*;

  // A load from the input wins over taking the neighbour's contents.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      stamp <= new_stamp;
      value <= new_value;
    end else if (ctrl.shift) begin
      stamp <= near_stamp;
      value <= near_value;
    end
  end

endmodule

// ===== sv/timestamped_sample_ring_with_retention.sv =====
// Top level of the timestamped sample ring with age-based retention.
// Depends on tsrr_pkg and tsrr_cell; the checker in tsrr_checker.sv binds to it.
// Push: the sample is written into the row when accepted, the cutoff is formed in ST_CUTOFF,
//   then ST_PRUNE drops head entries older than it before registering the acknowledgement.
// Query: the row is rotated once through all CAPACITY cells, one cell per cycle, in ST_SCAN,
//   and ST_FLUSH registers the final result; busy is high for the whole walk.
// Reset (synchronous rst): the ring is empty, the newest timestamp is the most negative
//   value and retention_span returns to 3600000; the cell contents are not cleared.
// Results are shown for one cycle on result_valid; the receiver cannot stall them.
module timestamped_sample_ring_with_retention #(
  parameter int CAPACITY = tsrr_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [tsrr_pkg::TIME_W-1:0]   sample_time,
  input  logic [tsrr_pkg::BITS_W-1:0]   sample_bits,
  input  logic [tsrr_pkg::TIME_W-1:0]   range_from,
  input  logic [tsrr_pkg::TIME_W-1:0]   range_to,
  // Result channel
  output logic                          result_valid,
  output logic                          kind,
  output logic                          has_sample,
  output logic [tsrr_pkg::TIME_W-1:0]   out_time,
  output logic [tsrr_pkg::BITS_W-1:0]   out_bits,
  output logic [tsrr_pkg::HELD_W-1:0]   held_count,
  output logic                          last,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [tsrr_pkg::SPAN_W-1:0]   pwdata,
  output logic [tsrr_pkg::SPAN_W-1:0]   prdata,
  output logic                          pready
);
  import tsrr_pkg::*;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUTOFF,
    ST_PRUNE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;

  // The row of cells. Cell 0 always holds the oldest entry outside a query walk, and
  // entries stay packed in push order towards higher cells. During a query the whole row
  // rotates by one each cycle, so after CAPACITY steps it is back where it started.
  logic [TIME_W-1:0] cell_stamp [CAPACITY];
  logic [BITS_W-1:0] cell_value [CAPACITY];
  cell_ctrl_t        cell_ctrl  [CAPACITY];

  logic [CNT_W-1:0]  held;
  logic [TIME_W-1:0] newest;
  logic [TIME_W-1:0] cutoff;
  logic [SPAN_W-1:0] retention_span;
  logic [TIME_W-1:0] lo_bound;
  logic [TIME_W-1:0] hi_bound;
  logic [SLOT_W-1:0] step;

  // A matching sample is held back until the next match or the end of the walk, so that the final one can carry last.
  logic              pend_valid;
  logic [TIME_W-1:0] pend_stamp;
  logic [BITS_W-1:0] pend_value;

  logic              accept;
  logic              push_accept;
  logic              full;
  logic              shift_all;
  logic [SLOT_W-1:0] load_slot;
  logic              prune_hit;
  logic              scan_hit;
  logic              scan_end;
  logic signed [TIME_W:0] cut_diff;
  logic [TIME_W-1:0] cutoff_next;
  logic              cfg_write;

  assign accept      = start && !busy;
  assign push_accept = accept && (op == OP_PUSH);
  assign full        = (held == CNT_W'(CAPACITY));
  assign busy        = (state != ST_IDLE);

  // A push into a full ring drops the oldest entry by shifting the row down and
  // writing the new sample into the top cell; otherwise it lands just above the newest.
  assign load_slot = full ? SLOT_W'(CAPACITY - 1) : held[SLOT_W-1:0];

  // The head is dropped while it is older than the cutoff.
  assign prune_hit = (held != '0) && ($signed(cell_stamp[0]) < $signed(cutoff));

  // During the walk the head cell is the entry of position step.
  assign scan_hit = (CNT_W'(step) < held)
                 && ($signed(cell_stamp[0]) >= $signed(lo_bound))
                 && ($signed(cell_stamp[0]) <= $signed(hi_bound));
  assign scan_end = (step == SLOT_W'(CAPACITY - 1));

  assign shift_all = (push_accept && full)
                  || ((state == ST_PRUNE) && prune_hit)
                  || (state == ST_SCAN);

  // Cutoff is the newest timestamp less the span, saturating at the most negative value.
  assign cut_diff    = $signed({newest[TIME_W-1], newest}) - $signed({1'b0, 32'd0, retention_span});
  assign cutoff_next = (cut_diff[TIME_W] != cut_diff[TIME_W-1]) ? TIME_MIN : cut_diff[TIME_W-1:0];

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_ctrl[i].shift = shift_all;
      assign cell_ctrl[i].load  = push_accept && (load_slot == SLOT_W'(i));

      tsrr_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .near_stamp (cell_stamp[(i + 1) % CAPACITY]),
        .near_value (cell_value[(i + 1) % CAPACITY]),
        .new_stamp  (sample_time),
        .new_value  (sample_bits),
        .stamp      (cell_stamp[i]),
        .value      (cell_value[i])
      );
    end
  endgenerate

  // Configuration register access. Writes must only arrive while idle; the block does not enforce this.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == REG_RETENTION) ? retention_span : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      retention_span <= RETENTION_RESET;
    end else if (cfg_write && (paddr == REG_RETENTION)) begin
      retention_span <= pwdata;
    end
  end

  // Sequencer with the ring bookkeeping and the registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      held         <= '0;
      newest       <= TIME_MIN;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            lo_bound <= range_from;
            hi_bound <= range_to;
            if (op == OP_PUSH) begin
              if (!full) begin
                held <= held + CNT_W'(1);
              end
              if ($signed(sample_time) > $signed(newest)) begin
                newest <= sample_time;
              end
              state <= ST_CUTOFF;
            end else begin
              step       <= '0;
              pend_valid <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_CUTOFF: begin
          cutoff <= cutoff_next;
          state  <= ST_PRUNE;
        end
        ST_PRUNE: begin
          if (prune_hit) begin
            held <= held - CNT_W'(1);
          end else begin
            result_valid <= 1'b1;
            kind         <= KIND_ACK;
            has_sample   <= 1'b0;
            out_time     <= '0;
            out_bits     <= '0;
            held_count   <= HELD_W'(held);
            last         <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            // A newer match exists, so the held-back one is not the final result.
            if (pend_valid) begin
              result_valid <= 1'b1;
              kind         <= KIND_QUERY;
              has_sample   <= 1'b1;
              out_time     <= pend_stamp;
              out_bits     <= pend_value;
              held_count   <= HELD_W'(held);
              last         <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_stamp <= cell_stamp[0];
            pend_value <= cell_value[0];
          end
          step <= step + SLOT_W'(1);
          if (scan_end) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          // Either the last match or, when nothing matched, the empty result.
          result_valid <= 1'b1;
          kind         <= KIND_QUERY;
          has_sample   <= pend_valid;
          out_time     <= pend_valid ? pend_stamp : '0;
          out_bits     <= pend_valid ? pend_value : '0;
          held_count   <= HELD_W'(held);
          last         <= 1'b1;
          pend_valid   <= 1'b0;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/tsrr_checker.sv =====
// Port-level checker for the timestamped sample ring, attached to the top level by bind.
// Depends on tsrr_pkg for codes and widths.
module tsrr_checker #(
  parameter int CAPACITY = tsrr_pkg::CAPACITY_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid,
  input logic                        kind,
  input logic                        has_sample,
  input logic [tsrr_pkg::HELD_W-1:0] held_count,
  input logic                        last
);
  import tsrr_pkg::*;

  // An accepted command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted command");

  // A push acknowledgement carries no sample and is always final.
  a_ack_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == KIND_ACK)) |-> (!has_sample && last))
    else $error("malformed push acknowledgement");

  // A result without a sample is the only result of its command.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !has_sample) |-> last)
    else $error("empty result not marked last");

  // The final result of a command coincides with the block becoming free again.
  a_last_free: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy)
    else $error("still busy on final result");

  // The count of held samples never exceeds the ring size.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (held_count <= HELD_W'(CAPACITY)))
    else $error("held count beyond capacity");

endmodule

bind timestamped_sample_ring_with_retention tsrr_checker #(
  .CAPACITY (CAPACITY)
) u_tsrr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .kind         (kind),
  .has_sample   (has_sample),
  .held_count   (held_count),
  .last         (last)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for timestamped_sample_ring_with_retention: pushes and range queries
// are checked against a cycle-free mirror of the ring. Depends on tsrr_pkg and the block's RTL.
module testbench;
  import tsrr_pkg::*;

  localparam int          DEPTH       = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          IDLE_PCT    = 37;
  localparam longint      EARLIEST    = longint'(TIME_MIN);
  localparam longint      LATEST      = ~EARLIEST;

  // One command transfer, every field carried whatever the operation.
  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] sample_time;
    logic [BITS_W-1:0] sample_bits;
    logic [TIME_W-1:0] range_from;
    logic [TIME_W-1:0] range_to;
  } ring_command_t;

  // One reply transfer as it should appear on the result ports.
  typedef struct packed {
    logic              kind;
    logic              has_sample;
    logic [TIME_W-1:0] out_time;
    logic [BITS_W-1:0] out_bits;
    logic [HELD_W-1:0] held_count;
    logic              last;
  } ring_reply_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              start       = 1'b0;
  logic              op          = OP_PUSH;
  logic [TIME_W-1:0] sample_time = '0;
  logic [BITS_W-1:0] sample_bits = '0;
  logic [TIME_W-1:0] range_from  = '0;
  logic [TIME_W-1:0] range_to    = '0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [1:0]        paddr       = REG_RETENTION;
  logic [SPAN_W-1:0] pwdata      = '0;

  logic              busy;
  logic              result_valid;
  logic              kind;
  logic              has_sample;
  logic [TIME_W-1:0] out_time;
  logic [BITS_W-1:0] out_bits;
  logic [HELD_W-1:0] held_count;
  logic              last;
  logic [SPAN_W-1:0] prdata;
  logic              pready;

  timestamped_sample_ring_with_retention #(.CAPACITY(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .op(op), .sample_time(sample_time),
    .sample_bits(sample_bits), .range_from(range_from), .range_to(range_to),
    .result_valid(result_valid), .kind(kind), .has_sample(has_sample),
    .out_time(out_time), .out_bits(out_bits), .held_count(held_count), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Commands waiting to be presented, and replies still owed by the block.
  ring_command_t commands_waiting[$];
  ring_reply_t   replies_due[$];
  ring_command_t presented;
  int            errors = 0;

  // Our own copy of the ring. Only held entries are ever read, so slots that were
  // never written may stay unknown.
  logic [TIME_W-1:0] mirror_times [DEPTH];
  logic [BITS_W-1:0] mirror_bits  [DEPTH];
  int                mirror_oldest = 0;
  int                mirror_held   = 0;
  longint            mirror_newest = EARLIEST;
  logic [SPAN_W-1:0] mirror_span   = RETENTION_RESET;

  // State of the stimulus generator: a wall clock that moves forward in random steps,
  // with late samples jittered behind it and query windows cut around it.
  longint            clock_ms    = 0;
  int unsigned       step_ms     = 1;
  int unsigned       jitter_ms   = 1;
  int unsigned       window_ms   = 1;
  logic [TIME_W-1:0] last_pushed = '0;
  bit                calm        = 1'b0;

  // Applies one accepted command to the mirror and queues the replies it owes.
  function automatic void apply_to_ring(input ring_command_t cmd);
    ring_reply_t reply;
    ring_reply_t held_back;
    longint      cutoff;
    longint      stamp;
    longint      span_ms;
    int          slot;
    int          i;
    bit          any;
    reply     = '0;
    held_back = '0;
    span_ms   = longint'({32'b0, mirror_span});
    if (cmd.op == OP_PUSH) begin
      // The new sample goes behind the newest; a full ring loses its oldest entry.
      slot = (mirror_oldest + mirror_held) % DEPTH;
      mirror_times[slot] = cmd.sample_time;
      mirror_bits[slot]  = cmd.sample_bits;
      if (mirror_held < DEPTH) mirror_held++;
      else mirror_oldest = (mirror_oldest + 1) % DEPTH;
      if (longint'(cmd.sample_time) > mirror_newest) mirror_newest = longint'(cmd.sample_time);
      // The cutoff saturates at the earliest representable timestamp.
      if (mirror_newest < EARLIEST + span_ms) cutoff = EARLIEST;
      else cutoff = mirror_newest - span_ms;
      // Retention only trims from the oldest end, so a late sample may linger behind
      // a younger one, or be dropped at once if everything ahead of it goes.
      while (mirror_held > 0 && longint'(mirror_times[mirror_oldest]) < cutoff) begin
        mirror_oldest = (mirror_oldest + 1) % DEPTH;
        mirror_held--;
      end
      reply.kind       = KIND_ACK;
      reply.held_count = HELD_W'(mirror_held);
      reply.last       = 1'b1;
      replies_due.insert(replies_due.size(), reply);
    end else begin
      // Walk oldest to newest; the final match is held back so that it can carry last.
      any = 1'b0;
      for (i = 0; i < mirror_held; i++) begin
        slot  = (mirror_oldest + i) % DEPTH;
        stamp = longint'(mirror_times[slot]);
        if (stamp >= longint'(cmd.range_from) && stamp <= longint'(cmd.range_to)) begin
          if (any) replies_due.insert(replies_due.size(), held_back);
          held_back            = '0;
          held_back.kind       = KIND_QUERY;
          held_back.has_sample = 1'b1;
          held_back.out_time   = mirror_times[slot];
          held_back.out_bits   = mirror_bits[slot];
          held_back.held_count = HELD_W'(mirror_held);
          any = 1'b1;
        end
      end
      if (any) begin
        held_back.last = 1'b1;
        replies_due.insert(replies_due.size(), held_back);
      end else begin
        // Nothing matched: a single empty reply still closes the query.
        reply.kind       = KIND_QUERY;
        reply.held_count = HELD_W'(mirror_held);
        reply.last       = 1'b1;
        replies_due.insert(replies_due.size(), reply);
      end
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Fields that the operation ignores are filled with noise all the same.
  function automatic void queue_push(input logic [TIME_W-1:0] stamp,
                                     input logic [BITS_W-1:0] raw);
    ring_command_t cmd;
    cmd.op          = OP_PUSH;
    cmd.sample_time = stamp;
    cmd.sample_bits = raw;
    cmd.range_from  = rand64();
    cmd.range_to    = rand64();
    last_pushed     = stamp;
    commands_waiting.insert(commands_waiting.size(), cmd);
  endfunction

  function automatic void queue_query(input logic [TIME_W-1:0] lo,
                                      input logic [TIME_W-1:0] hi);
    ring_command_t cmd;
    cmd.op          = OP_QUERY;
    cmd.sample_time = rand64();
    cmd.sample_bits = rand64();
    cmd.range_from  = lo;
    cmd.range_to    = hi;
    commands_waiting.insert(commands_waiting.size(), cmd);
  endfunction

  // Moves the wall clock on (saturating at the latest timestamp) and picks a push time:
  // mostly current, some late, a few far in the past anywhere in the negative half.
  function automatic logic [TIME_W-1:0] next_push_time();
    longint      step;
    int unsigned pick;
    step = longint'($urandom_range(step_ms));
    if (clock_ms > LATEST - step) clock_ms = LATEST;
    else clock_ms = clock_ms + step;
    pick = $urandom_range(99);
    if (pick < 5) return rand64() | {1'b1, 63'b0};
    if (pick < 25) return clock_ms - longint'($urandom_range(jitter_ms));
    return clock_ms;
  endfunction

  function automatic void queue_random_query();
    longint lo;
    longint hi;
    case ($urandom_range(9))
      0: queue_query(EARLIEST, LATEST);
      1: queue_query(rand64(), rand64());
      2: queue_query(last_pushed, last_pushed);
      3: begin
        // Bounds the wrong way round.
        lo = clock_ms - longint'($urandom_range(window_ms));
        hi = lo - 1 - longint'($urandom_range(window_ms));
        queue_query(lo, hi);
      end
      default: begin
        hi = clock_ms - longint'($urandom_range(jitter_ms));
        lo = hi - longint'($urandom_range(window_ms));
        queue_query(lo, hi);
      end
    endcase
  endfunction

  function automatic void queue_random(input int count, input int push_pct);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < push_pct) queue_push(next_push_time(), rand64());
      else queue_random_query();
    end
  endfunction

  // Returns once every command has been transferred, the block is idle and no reply
  // is owed. Checked on the falling edge, clear of the rising-edge updates.
  task automatic wait_quiet();
    do @(negedge clk);
    while (commands_waiting.size() != 0 || start || busy || replies_due.size() != 0);
  endtask

  // APB write of retention_span: a setup cycle, then an access cycle that completes at
  // the edge where pready is seen high. Only called while the block is idle.
  task automatic write_span(input logic [SPAN_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RETENTION;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror_span = value;
    @(negedge clk);
  endtask

  // Command driver. A transfer completes at an edge where start is high and busy is low;
  // the mirror is updated at that edge. A new command is offered only when none is held,
  // with random idle cycles unless the current phase asks for a calm stretch.
  always @(posedge clk) begin : command_driver
    bit pause;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_to_ring(presented);
      if (!start || !busy) begin
        pause = !calm && ($urandom_range(99) < IDLE_PCT);
        if (commands_waiting.size() != 0 && !pause) begin
          presented = commands_waiting.pop_front();
          start       <= 1'b1;
          op          <= presented.op;
          sample_time <= presented.sample_time;
          sample_bits <= presented.sample_bits;
          range_from  <= presented.range_from;
          range_to    <= presented.range_to;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // Reply monitor. The receiver cannot stall, so every strobed cycle is a transfer and is
  // matched against the oldest reply owed.
  always @(posedge clk) begin : reply_monitor
    ring_reply_t want;
    if (!rst && result_valid) begin
      if (replies_due.size() == 0) begin
        $error("unexpected reply: kind %0d, held_count %0d", kind, held_count);
        errors++;
      end else begin
        want = replies_due.pop_front();
        check_field("kind", want.kind, kind);
        check_field("has_sample", want.has_sample, has_sample);
        check_field("out_time", want.out_time, out_time);
        check_field("out_bits", want.out_bits, out_bits);
        check_field("held_count", want.held_count, held_count);
        check_field("last", want.last, last);
      end
    end
  end

  int unsigned cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    longint      far_ahead;
    int unsigned span_pick;
    int          n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening under the reset retention of one hour.
    queue_query(EARLIEST, LATEST);              // empty ring
    queue_push(EARLIEST, '1);                   // earliest timestamp, all-ones value
    queue_push(EARLIEST + 5, '0);               // cutoff saturates, nothing dropped
    queue_query(EARLIEST, EARLIEST);            // single-point range at the bottom
    queue_query(5, -5);                         // lower bound above the upper
    queue_query(EARLIEST, LATEST);              // everything held
    queue_query(0, LATEST);                     // nothing matches, ring not empty
    queue_push(0, 64'hA5A5_5A5A_0F0F_F0F0);     // both early samples fall out
    queue_push(-4000000, 64'h5A5A_A5A5_F0F0_0F0F); // late sample kept behind a newer one
    queue_push(-3600000, 64'h8000_0000_0000_0001);
    queue_push(3600000, 64'h7FFF_FFFF_FFFF_FFFE); // oldest sits exactly on the cutoff
    queue_push(3600001, rand64());              // drops the head and the late ones
    queue_query(-LATEST, LATEST);
    queue_query(3600001, 3600001);
    queue_query(rand64(), rand64());
    wait_quiet();

    // Widest retention, with large clock steps. Midway the sender
    // holds back until every reply has come.
    write_span('1);
    clock_ms  = mirror_newest;
    step_ms   = 100000000;
    jitter_ms = 50000000;
    window_ms = 1000000000;
    queue_random(40, 75);
    wait_quiet();
    queue_random(40, 75);
    wait_quiet();

    // Zero retention with tiny steps, so equal timestamps are common; no idle cycles.
    write_span('0);
    calm      = 1'b1;
    clock_ms  = mirror_newest;
    step_ms   = 3;
    jitter_ms = 2;
    window_ms = 4;
    queue_random(60, 60);
    wait_quiet();
    calm = 1'b0;

    // Moderate retention with steady traffic.
    write_span($urandom_range(50000, 1000));
    clock_ms  = mirror_newest;
    step_ms   = 5000;
    jitter_ms = 20000;
    window_ms = 30000;
    queue_random(80, 65);
    wait_quiet();

    // A push far ahead leaves it alone in the ring; a full ring of stale samples follows,
    // and the one that overwrites it makes every entry, itself included, age out at once.
    span_pick = $urandom_range(1000000, 1000);
    write_span(span_pick);
    far_ahead = mirror_newest + 4 * longint'(span_pick) + 1000;
    queue_push(far_ahead, rand64());
    for (n = 0; n < DEPTH; n++)
      queue_push(far_ahead - longint'(span_pick) - 1 - longint'($urandom_range(span_pick)),
                 rand64());
    queue_query(EARLIEST, LATEST);
    clock_ms  = far_ahead;
    step_ms   = span_pick / 4;
    jitter_ms = span_pick / 2;
    window_ms = span_pick;
    queue_random(10, 60);
    wait_quiet();

    // Top of the timestamp range: the clock saturates and pushes land on the latest value.
    write_span($urandom_range(20000, 1));
    clock_ms  = LATEST - 300000;
    step_ms   = 20000;
    jitter_ms = 10000;
    window_ms = 40000;
    queue_random(70, 70);
    wait_quiet();

    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
